// ----- design/kmc_pkg.sv -----
// ----------------------------------------------------------------------------
// KMC event select package
// Shared widths, action codes and item types for the rate roulette select.
// ----------------------------------------------------------------------------
`default_nettype none

package kmc_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int RATE_W      = 48;
   localparam int ENTRY_W     = RATE_W + 1;
   localparam int TOT_W       = 58;
   localparam int DRAW_W      = 32;
   localparam int TAG_W       = 16;
   localparam int TS_W        = 64;
   localparam int LOG_FRAC    = 40;

   localparam logic [TOT_W-1:0] TOTAL_MAX = '1;
   localparam logic [63:0]      LN2_Q64   = 64'hB17217F7D1CF79AB;
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_ENTRIES);

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_LOAD   = 2'd1;
   localparam logic [1:0] ACT_CHOOSE = 2'd2;

   typedef struct packed {
      logic [DRAW_W-1:0] draw_select;
      logic [DRAW_W-1:0] draw_time;
      logic [TAG_W-1:0]  basin_tag;
      logic [TOT_W-1:0]  total;
      logic [CNT_W-1:0]  count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- design/kmc_if.sv -----
// ----------------------------------------------------------------------------
// KMC channel interfaces
// Valid/ready channels for clear, load and choose items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmc_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [kmc_pkg::RATE_W-1:0]    entry_rate;
   logic                          entry_exit;
   logic [kmc_pkg::DRAW_W-1:0]    draw_select;
   logic [kmc_pkg::DRAW_W-1:0]    draw_time;
   logic [kmc_pkg::TAG_W-1:0]     basin_tag;

   modport source(output valid, action, entry_rate, entry_exit, draw_select, draw_time,
                  basin_tag, input ready);
   modport sink(input valid, action, entry_rate, entry_exit, draw_select, draw_time,
                basin_tag, output ready);
endinterface

interface kmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kmc_pkg::IDX_W-1:0]     chosen_index;
   logic [kmc_pkg::TS_W-1:0]      time_step;
   logic [kmc_pkg::TAG_W-1:0]     basin_out;
   logic                          status;

   modport source(output valid, chosen_index, time_step, basin_out, status, input ready);
   modport sink(input valid, chosen_index, time_step, basin_out, status, output ready);
endinterface

`default_nettype wire

// ----- design/kmc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- design/kmc_front.sv -----
// ----------------------------------------------------------------------------
// KMC front end
// Accepts items, applies clear and load to the table, queues choose jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   kmc_req_if.sink                        req_ch,
   input  wire kmc_pkg::queue_status_type qstat,
   input  wire logic                      back_busy,
   output logic                           push_vld,
   output kmc_pkg::job_type               push_job,
   output logic                           wr_en,
   output logic [kmc_pkg::IDX_W-1:0]      wr_addr,
   output logic [kmc_pkg::ENTRY_W-1:0]    wr_data
);
   import kmc_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [TOT_W:0]   total_add;
   logic             accept;

   // table edits wait until no choose job is pending
   assign req_ch.ready = (req_ch.action == ACT_CHOOSE) ? !qstat.full
                                                       : (qstat.empty && !back_busy);
   assign accept    = req_ch.valid && req_ch.ready;
   assign total_add = {1'b0, total_ff} + (TOT_W+1)'(req_ch.entry_rate);

   assign wr_addr  = count_ff[IDX_W-1:0];
   assign wr_data  = {req_ch.entry_exit, req_ch.entry_rate};
   assign wr_en    = accept && (req_ch.action == ACT_LOAD) && (count_ff < CNT_FULL);
   assign push_vld = accept && (req_ch.action == ACT_CHOOSE);

   always_comb begin
      push_job.draw_select = req_ch.draw_select;
      push_job.draw_time   = req_ch.draw_time;
      push_job.basin_tag   = req_ch.basin_tag;
      push_job.total       = total_ff;
      push_job.count       = count_ff;
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      if (accept && req_ch.action == ACT_CLEAR) begin
         count_in = '0;
         total_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
         total_in = total_add[TOT_W] ? TOTAL_MAX : total_add[TOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/kmc_queue.sv -----
// ----------------------------------------------------------------------------
// KMC job queue
// Two-entry queue of choose jobs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_vld,
   input  wire kmc_pkg::job_type           push_job,
   input  wire logic                       pop,
   output kmc_pkg::job_type                head,
   output kmc_pkg::queue_status_type       qstat
);
   import kmc_pkg::*;

   job_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign qstat.full  = (fill_ff == 2'd2);
   assign qstat.empty = (fill_ff == 2'd0);
   assign do_push     = push_vld && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      fill_in = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/kmc_back.sv -----
// ----------------------------------------------------------------------------
// KMC back end
// Walks the rate table for a choose job and computes the time step.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire kmc_pkg::job_type           head,
   input  wire kmc_pkg::queue_status_type  qstat,
   output logic                            pop,
   output logic                            back_busy,
   output logic [kmc_pkg::IDX_W-1:0]       rd_addr,
   input  wire logic [kmc_pkg::ENTRY_W-1:0] rd_data,
   kmc_rsp_if.source                       rsp_ch
);
   import kmc_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LIM0  = 4'd1;
   localparam logic [3:0] ST_LIM1  = 4'd2;
   localparam logic [3:0] ST_WALK  = 4'd3;
   localparam logic [3:0] ST_TIME  = 4'd4;
   localparam logic [3:0] ST_NORM  = 4'd5;
   localparam logic [3:0] ST_LOG   = 4'd6;
   localparam logic [3:0] ST_LNMUL = 4'd7;
   localparam logic [3:0] ST_DIVS  = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   localparam int LIM_W  = DRAW_W + TOT_W;
   localparam int HALF_T = TOT_W / 2;
   localparam int ACC_W  = 110;
   localparam int V_W    = 46;
   localparam int VH_W   = V_W / 2;

   logic [3:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [TOT_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [4:0]        n_ff, n_in;
   logic [31:0]       y_ff, y_in;
   logic [LOG_FRAC-1:0] f_ff, f_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [TOT_W-1:0]  r_ff, r_in;
   logic [TS_W-1:0]   lo_ff, lo_in;
   logic [TS_W-1:0]   q_ff, q_in;
   logic              st_ff, st_in;

   logic              out_vld_ff, out_vld_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [TS_W-1:0]   out_ts_ff, out_ts_in;
   logic [TAG_W-1:0]  out_tag_ff, out_tag_in;
   logic              out_st_ff, out_st_in;

   logic [60:0]       lim_pp;
   logic [TOT_W:0]    sum_add;
   logic [TOT_W-1:0]  sum_sat;
   logic              hit;
   logic [63:0]       y_sq;
   logic [32:0]       sq_sh;
   logic [V_W-1:0]    v_val;
   logic [VH_W-1:0]   v_part;
   logic [31:0]       ln_part;
   logic [54:0]       ln_pp;
   logic [6:0]        ln_sh;
   logic [TOT_W:0]    r_sh;
   logic              can_out;

   assign back_busy = (state_ff != ST_IDLE);
   assign can_out   = !out_vld_ff || rsp_ch.ready;

   assign lim_pp  = 61'(job_ff.draw_select) *
                    61'((state_ff == ST_LIM0) ? job_ff.total[HALF_T-1:0]
                                              : job_ff.total[TOT_W-1:HALF_T]);
   assign sum_add = {1'b0, sum_ff} + (TOT_W+1)'(rd_data[RATE_W-1:0]);
   assign sum_sat = sum_add[TOT_W] ? TOTAL_MAX : sum_add[TOT_W-1:0];
   assign hit     = {sum_sat, 32'b0} > limit_ff;

   assign y_sq    = {32'b0, y_ff} * {32'b0, y_ff};
   assign sq_sh   = y_sq[63:31];
   assign v_val   = {6'(7'd32 - 7'(n_ff)), {LOG_FRAC{1'b0}}} - V_W'(f_ff);
   assign v_part  = cnt_ff[0] ? v_val[V_W-1:VH_W] : v_val[VH_W-1:0];
   assign ln_part = cnt_ff[1] ? LN2_Q64[63:32] : LN2_Q64[31:0];
   assign ln_pp   = 55'(v_part) * 55'(ln_part);
   assign ln_sh   = (cnt_ff[0] ? 7'(VH_W) : 7'd0) + (cnt_ff[1] ? 7'd32 : 7'd0);
   assign r_sh    = {r_ff, lo_ff[TS_W-1]};

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      limit_in  = limit_ff;
      sum_in    = sum_ff;
      walk_in   = walk_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      pick_in   = pick_ff;
      n_in      = n_ff;
      y_in      = y_ff;
      f_in      = f_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      r_in      = r_ff;
      lo_in     = lo_ff;
      q_in      = q_ff;
      st_in     = st_ff;
      pop       = 1'b0;
      rd_addr   = walk_ff[IDX_W-1:0];
      out_vld_in = out_vld_ff && !rsp_ch.ready;
      out_idx_in = out_idx_ff;
      out_ts_in  = out_ts_ff;
      out_tag_in = out_tag_ff;
      out_st_in  = out_st_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               job_in   = head;
               state_in = ST_LIM0;
            end
         end
         ST_LIM0: begin
            limit_in = LIM_W'(lim_pp);
            sum_in   = '0;
            walk_in  = '0;
            state_in = ST_LIM1;
         end
         ST_LIM1: begin
            limit_in = limit_ff + (LIM_W'(lim_pp) << HALF_T);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (rd_vld_ff && rd_data[RATE_W] && hit) begin
               pick_in  = rd_idx_ff;
               state_in = ST_TIME;
            end else begin
               if (rd_vld_ff && rd_data[RATE_W]) begin
                  sum_in = sum_sat;
               end
               if (walk_ff < job_ff.count) begin
                  rd_vld_in = 1'b1;
                  rd_idx_in = walk_ff[IDX_W-1:0];
                  walk_in   = walk_ff + CNT_W'(1);
               end else if (!rd_vld_ff) begin
                  st_in    = 1'b1;
                  pick_in  = '0;
                  q_in     = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_TIME: begin
            st_in = 1'b0;
            y_in  = job_ff.draw_time;
            n_in  = 5'd31;
            if (job_ff.draw_time == '0 || job_ff.total == '0) begin
               q_in     = '1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (y_ff[31]) begin
               cnt_in   = '0;
               f_in     = '0;
               state_in = ST_LOG;
            end else begin
               y_in = {y_ff[30:0], 1'b0};
               n_in = n_ff - 5'd1;
            end
         end
         ST_LOG: begin
            f_in   = {f_ff[LOG_FRAC-2:0], sq_sh[32]};
            y_in   = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(LOG_FRAC - 1)) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_LNMUL;
            end
         end
         ST_LNMUL: begin
            acc_in = acc_ff + (ACC_W'(ln_pp) << ln_sh);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            // L = acc[109:64]; numerator is L << 24
            cnt_in = '0;
            q_in   = '0;
            r_in   = TOT_W'(acc_ff[ACC_W-1:104]);
            lo_in  = {acc_ff[103:64], 24'b0};
            if (TOT_W'(acc_ff[ACC_W-1:104]) >= job_ff.total) begin
               q_in     = '1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            lo_in  = {lo_ff[TS_W-2:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (r_sh >= {1'b0, job_ff.total}) begin
               r_in = TOT_W'(r_sh - {1'b0, job_ff.total});
               q_in = {q_ff[TS_W-2:0], 1'b1};
            end else begin
               r_in = r_sh[TOT_W-1:0];
               q_in = {q_ff[TS_W-2:0], 1'b0};
            end
            if (cnt_ff == 6'd63) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (can_out) begin
               out_vld_in = 1'b1;
               out_idx_in = pick_ff;
               out_ts_in  = q_ff;
               out_tag_in = job_ff.basin_tag;
               out_st_in  = st_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      limit_ff   <= limit_in;
      sum_ff     <= sum_in;
      walk_ff    <= walk_in;
      rd_idx_ff  <= rd_idx_in;
      pick_ff    <= pick_in;
      n_ff       <= n_in;
      y_ff       <= y_in;
      f_ff       <= f_in;
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      r_ff       <= r_in;
      lo_ff      <= lo_in;
      q_ff       <= q_in;
      st_ff      <= st_in;
      out_idx_ff <= out_idx_in;
      out_ts_ff  <= out_ts_in;
      out_tag_ff <= out_tag_in;
      out_st_ff  <= out_st_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.chosen_index = out_idx_ff;
   assign rsp_ch.time_step    = out_ts_ff;
   assign rsp_ch.basin_out    = out_tag_ff;
   assign rsp_ch.status       = out_st_ff;

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> r_ff < job_ff.total)
      else $error("division remainder not below total");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> walk_ff <= job_ff.count)
      else $error("walk index beyond entry count");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_st_ff |-> out_ts_ff == '0 && out_idx_ff == '0)
      else $error("missed selection with nonzero fields");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_LIM0)
      else $error("job popped without starting");

endmodule

`default_nettype wire

// ----- design/kmc_rate_roulette_select_unit.sv -----
// ----------------------------------------------------------------------------
// KMC rate roulette select unit
// Rate table with running total; picks an event and a time step per choose.
// ----------------------------------------------------------------------------
// Clear and load items take one cycle, and wait while a choose item is pending.
// After leaving the queue, a choose item forms its limit and walks the stored
// entries (one per cycle, set by the single table read port); a pick then goes
// through normalize, log squarings, ln multiply and bit-serial divide. One choose
// item is processed at a time; two more may queue. Reset clears count, total,
// queue state and back-end state; the table keeps its contents.
`default_nettype none

module kmc_rate_roulette_select_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   kmc_req_if.sink    req_ch,
   kmc_rsp_if.source  rsp_ch
);
   import kmc_pkg::*;

   queue_status_type    qstat;
   job_type             push_job;
   job_type             head;
   logic                push_vld;
   logic                pop;
   logic                back_busy;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  rd_data;

   kmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .qstat     (qstat),
      .back_busy (back_busy),
      .push_vld  (push_vld),
      .push_job  (push_job),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   kmc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_vld (push_vld),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   kmc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .back_busy (back_busy),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- sim/tb_kmc_rate_roulette_select_unit.sv -----
// ----------------------------------------------------------------------------
// Rate roulette select unit testbench
// Drives clear, load, choose and spare-action items over the request channel with random
// gaps and receiver stalls, predicts each choose result from a local copy of
// the rate table and checks the returned index, time step, tag and status.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_kmc_rate_roulette_select_unit;
   import kmc_pkg::*;

   localparam logic [1:0] ACT_SPARE = 2'd3;

   typedef struct {
      logic [IDX_W-1:0] chosen_index;
      logic [TS_W-1:0]  time_step;
      logic [TAG_W-1:0] basin_out;
      logic             status;
   } pick_type;

   logic clock = 1'b0;
   logic reset;

   kmc_req_if req ();
   kmc_rsp_if rsp ();

   kmc_rate_roulette_select_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   always #5 clock = ~clock;

   logic [RATE_W-1:0] table_rate [MAX_ENTRIES];
   logic              table_exit [MAX_ENTRIES];
   int unsigned       table_count;
   logic [TOT_W-1:0]  table_total;
   pick_type          expected_picks [$];
   int                mismatch_count = 0;
   bit                steady = 1'b0;
   int                hold_request = 0;
   int                items_sent = 0;

   function automatic logic [TS_W-1:0] neg_log_step(logic [31:0] d, logic [TOT_W-1:0] tot);
      int n;
      logic [63:0]  y;
      logic [63:0]  f;
      logic [63:0]  v;
      logic [127:0] prod;
      logic [63:0]  lq;
      logic [127:0] q;
      if (d == 0 || tot == 0) return '1;
      n = 31;
      while (d[n] == 1'b0) n--;
      y = 64'(d) << (31 - n);
      f = '0;
      for (int i = 0; i < LOG_FRAC; i++) begin
         y = (y * y) >> 31;
         f = f << 1;
         if (y >= 64'h1_0000_0000) begin
            f[0] = 1'b1;
            y = y >> 1;
         end
      end
      v = (64'(32 - n) << LOG_FRAC) - f;
      prod = 128'(v) * 128'(LN2_Q64);
      lq = prod[127:64];
      if ((lq >> 40) >= 64'(tot)) return '1;
      q = (128'(lq) << 24) / 128'(tot);
      return q[63:0];
   endfunction

   function automatic void predict_item(logic [1:0] act, logic [RATE_W-1:0] rate, logic ex,
                                        logic [31:0] ds, logic [31:0] dt, logic [15:0] tag);
      logic [95:0]      limit;
      logic [TOT_W-1:0] sum;
      pick_type         p;
      bit               found;
      case (act)
         ACT_CLEAR: begin
            table_count = 0;
            table_total = '0;
         end
         ACT_LOAD: begin
            if (table_count < MAX_ENTRIES) begin
               table_rate[table_count] = rate;
               table_exit[table_count] = ex;
               table_count++;
               table_total = (TOTAL_MAX - table_total < rate) ? TOTAL_MAX : table_total + rate;
            end
         end
         ACT_CHOOSE: begin
            limit = 96'(ds) * 96'(table_total);
            sum = '0;
            found = 1'b0;
            p.chosen_index = '0;
            for (int i = 0; i < table_count; i++) begin
               if (table_exit[i]) begin
                  sum = (TOTAL_MAX - sum < table_rate[i]) ? TOTAL_MAX : sum + table_rate[i];
                  if ((96'(sum) << 32) > limit) begin
                     found = 1'b1;
                     p.chosen_index = IDX_W'(i);
                     break;
                  end
               end
            end
            p.basin_out = tag;
            p.status = !found;
            p.time_step = found ? neg_log_step(dt, table_total) : '0;
            expected_picks.push_back(p);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(logic [1:0] act, logic [RATE_W-1:0] rate, logic ex,
                            logic [31:0] ds, logic [31:0] dt, logic [15:0] tag);
      int gap;
      req.valid       <= 1'b1;
      req.action      <= act;
      req.entry_rate  <= rate;
      req.entry_exit  <= ex;
      req.draw_select <= ds;
      req.draw_time   <= dt;
      req.basin_tag   <= tag;
      do @(posedge clock); while (!req.ready);
      predict_item(act, rate, ex, ds, dt, tag);
      items_sent++;
      gap = 0;
      if (!steady) begin
         if ($urandom_range(0, 99) < 60) gap = 0;
         else if ($urandom_range(0, 99) < 90) gap = $urandom_range(1, 3);
         else gap = $urandom_range(15, 60);
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic do_clear();
      send_item(ACT_CLEAR, RATE_W'({$urandom, $urandom}), 1'($urandom), $urandom, $urandom,
                16'($urandom));
   endtask

   task automatic do_load(logic [RATE_W-1:0] rate, logic ex);
      send_item(ACT_LOAD, rate, ex, $urandom, $urandom, 16'($urandom));
   endtask

   task automatic do_choose(logic [31:0] ds, logic [31:0] dt, logic [15:0] tag);
      send_item(ACT_CHOOSE, RATE_W'({$urandom, $urandom}), 1'($urandom), ds, dt, tag);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      do @(posedge clock); while (expected_picks.size() != 0);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic [RATE_W-1:0] random_rate();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return RATE_W'({$urandom, $urandom});
         default: return RATE_W'($urandom_range(1, 1 << 20));
      endcase
   endfunction

   task automatic test_directed();
      do_clear();
      do_choose(32'h8000_0000, 32'h8000_0000, 16'h0000);
      do_load(48'h0, 1'b1);
      do_choose(32'h0, 32'h1234_5678, 16'hFFFF);
      do_load(48'hFFFF_FFFF_FFFF, 1'b0);
      do_choose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5A5A);
      do_load(48'h0001_0000, 1'b1);
      do_load(48'hFFFF_FFFF_FFFF, 1'b1);
      do_choose(32'h0, 32'h0, 16'hA5A5);
      do_choose(32'hFFFF_FFFF, 32'h1, 16'h0001);
      do_choose(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
      send_item(ACT_SPARE, '1, 1'b1, '1, '1, '1);
      do_choose(32'h0000_0001, 32'h0000_8000, 16'h00FF);
      do_clear();
      do_load(48'h1, 1'b1);
      do_choose(32'h0, 32'h8000_0000, 16'h1111);
      do_choose(32'hFFFF_FFFF, 32'h4000_0000, 16'h2222);
      wait_drained();
   endtask

   task automatic test_full_table();
      do_clear();
      for (int i = 0; i < MAX_ENTRIES - 1; i++) do_load(RATE_W'($urandom_range(1, 255)), 1'b1);
      do_load(48'h0100_0000_0000, 1'b1);
      do_load(48'hFFFF_FFFF_FFFF, 1'b1);
      do_choose(32'hFFFF_FFFF, $urandom, 16'($urandom));
      do_choose(32'h0, $urandom, 16'($urandom));
      do_choose($urandom, $urandom, 16'($urandom));
      wait_drained();
   endtask

   task automatic test_backpressure();
      do_clear();
      for (int i = 0; i < 6; i++) do_load(random_rate(), 1'b1);
      wait_drained();
      hold_request = 400;
      steady = 1'b1;
      for (int i = 0; i < 8; i++) do_choose($urandom, $urandom, 16'($urandom));
      do_load(random_rate(), 1'b1);
      do_choose($urandom, $urandom, 16'($urandom));
      steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_random();
      int n;
      while (items_sent < 580 + MAX_ENTRIES + 40) begin
         steady = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 9) < 8) do_clear();
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 12);
         for (int i = 0; i < n; i++) do_load(random_rate(), $urandom_range(0, 9) < 8);
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 14) == 0) send_item(ACT_SPARE, RATE_W'({$urandom, $urandom}),
                                                      1'($urandom), $urandom, $urandom,
                                                      16'($urandom));
            else if ($urandom_range(0, 14) == 0) do_load(random_rate(), 1'($urandom));
            do_choose($urandom, ($urandom_range(0, 29) == 0) ? 32'h0 : $urandom,
                      16'($urandom));
         end
      end
      steady = 1'b0;
      wait_drained();
   endtask

   // result sink: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      static int hold_left = 0;
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (steady) begin
         rsp.ready <= 1'b1;
      end else begin
         if ($urandom_range(0, 99) < 2) hold_left = $urandom_range(10, 40);
         rsp.ready <= ($urandom_range(0, 99) < 75);
      end
   end

   always @(posedge clock) begin
      pick_type p;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_picks.size() == 0) begin
            $error("unexpected result item: index %0d tag %h", rsp.chosen_index,
                   rsp.basin_out);
            mismatch_count++;
         end else begin
            p = expected_picks.pop_front();
            if (rsp.chosen_index !== p.chosen_index) begin
               $error("chosen_index expected %0d actual %0d", p.chosen_index,
                      rsp.chosen_index);
               mismatch_count++;
            end
            if (rsp.time_step !== p.time_step) begin
               $error("time_step expected %h actual %h", p.time_step, rsp.time_step);
               mismatch_count++;
            end
            if (rsp.basin_out !== p.basin_out) begin
               $error("basin_out expected %h actual %h", p.basin_out, rsp.basin_out);
               mismatch_count++;
            end
            if (rsp.status !== p.status) begin
               $error("status expected %0d actual %0d", p.status, rsp.status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.action      <= ACT_CLEAR;
      req.entry_rate  <= '0;
      req.entry_exit  <= 1'b0;
      req.draw_select <= '0;
      req.draw_time   <= '0;
      req.basin_tag   <= '0;
      table_count = 0;
      table_total = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      test_random();
      if (mismatch_count == 0 && expected_picks.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
design/kmc_pkg.sv
design/kmc_if.sv
design/kmc_ram.sv
design/kmc_front.sv
design/kmc_queue.sv
design/kmc_back.sv
design/kmc_rate_roulette_select_unit.sv
sim/tb_kmc_rate_roulette_select_unit.sv
